// ===== sv/cnc_pkg.sv =====
package cnc_pkg;

  // fixed-point levels
  localparam int FRAC_BITS = 16;
  localparam int LEVEL_W   = FRAC_BITS + 1;
  localparam int FREQ_W    = 20;
  localparam int NUM_CH    = 3;
  localparam int CLASS_W   = 3;
  localparam int IDX_W     = 3;

  // stream packing
  localparam int IN_W        = NUM_CH * FREQ_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = NUM_CH * LEVEL_W + CLASS_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // threshold compares: level > num/den  <=>  level * den > num << FRAC_BITS
  localparam int TH_W = LEVEL_W + 5;
  localparam logic [TH_W-1:0] ONE_LEVEL = TH_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    KIND_DIV,
    KIND_ZERO,
    KIND_SAT
  } kind_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_RED     = 3'd0,
    CLS_GREEN   = 3'd1,
    CLS_BLUE    = 3'd2,
    CLS_WHITE   = 3'd3,
    CLS_BLACK   = 3'd4,
    CLS_UNKNOWN = 3'd5
  } cls_e;

  typedef enum logic [IDX_W-1:0] {
    REG_BLACK_RED   = 3'd0,
    REG_BLACK_GREEN = 3'd1,
    REG_BLACK_BLUE  = 3'd2,
    REG_WHITE_RED   = 3'd3,
    REG_WHITE_GREEN = 3'd4,
    REG_WHITE_BLUE  = 3'd5
  } reg_e;

  typedef logic [FREQ_W-1:0]  freq_t;
  typedef freq_t [NUM_CH-1:0] freq3_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef level_t [NUM_CH-1:0] level3_t;

  // one channel's partial division
  typedef struct packed {
    kind_e                kind;
    logic [FREQ_W-1:0]    rem;
    logic [FRAC_BITS-1:0] quo;
  } chan_t;

  typedef chan_t [NUM_CH-1:0] trip_t;

endpackage

// ===== sv/color_normalize_classify.sv =====
// Two-point calibrated colour classifier. Each beat on the slave stream is a
// red, green and blue frequency triple; each channel is mapped between its
// black and white calibration points to an unsigned Q1.16 level (65536 is
// full white), truncated and clamped, with zero where the reading is at or
// below black or the white point is not above black. The triple is then
// classified as red, green, blue, white, black or unknown. One triple is
// taken per clock while the input stage is free to accept it; every stage
// holds its own beat, so while a result waits on the master side the block
// keeps accepting until all eighteen stages hold a beat. A triple passes
// through one input stage that subtracts the black point and sorts out the
// zero and saturated cases, a row of 16 division cells that each produce
// one quotient bit for all three channels, and the output register holding
// the levels and the class. Calibration registers are written through the
// cfg port, always ready, and are meant to change only while no triple is
// in flight; indexes above five are ignored.
module color_normalize_classify (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // calibration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cnc_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [cnc_pkg::FREQ_W-1:0]          cfg_data_i,
  // frequency triples
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: red_freq, green_freq, blue_freq, zero pad
  input  logic [cnc_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // levels and class
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata: norm_red, norm_green, norm_blue, color_class, zero pad
  output logic [cnc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import cnc_pkg::*;

  // calibration points, per channel red/green/blue
  freq3_t  black_q, white_q;
  freq3_t  divisor;
  logic [NUM_CH-1:0] cal_ok;

  // input stage
  freq3_t  freq_in;
  trip_t   pre_d, pre_q;
  logic    pre_valid_q;

  // cell row, index 0 is the input stage
  logic    cell_valid [FRAC_BITS+1];
  logic    cell_ready [FRAC_BITS+1];
  trip_t   cell_data  [FRAC_BITS+1];

  // output register
  level3_t levels;
  cls_e    cls;
  level3_t out_lvl_q;
  cls_e    out_cls_q;
  logic    out_valid_q;
  logic    out_ready;

  // ---------------------------------------------------------------------
  // calibration registers
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q <= '0;
      white_q <= {NUM_CH{FREQ_W'(1)}};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BLACK_RED:   black_q[0] <= cfg_data_i;
        REG_BLACK_GREEN: black_q[1] <= cfg_data_i;
        REG_BLACK_BLUE:  black_q[2] <= cfg_data_i;
        REG_WHITE_RED:   white_q[0] <= cfg_data_i;
        REG_WHITE_GREEN: white_q[1] <= cfg_data_i;
        REG_WHITE_BLUE:  white_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // span between the two points; only used where white is above black
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      cal_ok[c]  = white_q[c] > black_q[c];
      divisor[c] = white_q[c] - black_q[c];
    end
  end

  // ---------------------------------------------------------------------
  // input stage: subtract black, pick zero / saturated / divide
  // ---------------------------------------------------------------------
  // with black < reading < white the remainder starts below the divisor,
  // so sixteen steps give the whole quotient
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      freq_in[c]   = s_axis_tdata_i[c*FREQ_W +: FREQ_W];
      pre_d[c].rem = freq_in[c] - black_q[c];
      pre_d[c].quo = '0;
      if (!cal_ok[c] || freq_in[c] <= black_q[c]) begin
        pre_d[c].kind = KIND_ZERO;
      end else if (freq_in[c] >= white_q[c]) begin
        pre_d[c].kind = KIND_SAT;
      end else begin
        pre_d[c].kind = KIND_DIV;
      end
    end
  end

  assign s_axis_tready_o = ~pre_valid_q | cell_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      pre_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      pre_q <= pre_d;
    end
  end

  // ---------------------------------------------------------------------
  // row of division cells, each beat moves on as soon as the next is free
  // ---------------------------------------------------------------------
  assign cell_valid[0] = pre_valid_q;
  assign cell_data[0]  = pre_q;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    cnc_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (cell_valid[i]),
      .ready_o   (cell_ready[i]),
      .data_i    (cell_data[i]),
      .divisor_i (divisor),
      .valid_o   (cell_valid[i+1]),
      .ready_i   (cell_ready[i+1]),
      .data_o    (cell_data[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // clamp, classify and register the result
  // ---------------------------------------------------------------------
  cnc_classify u_classify (
    .data_i   (cell_data[FRAC_BITS]),
    .levels_o (levels),
    .class_o  (cls)
  );

  assign out_ready             = ~out_valid_q | m_axis_tready_i;
  assign cell_ready[FRAC_BITS] = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= cell_valid[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && cell_valid[FRAC_BITS]) begin
      out_lvl_q <= levels;
      out_cls_q <= cls;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_cls_q, out_lvl_q[2], out_lvl_q[1],
                                         out_lvl_q[0]});

`ifndef SYNTHESIS
  // a level never goes past full white
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_lvl_q[0] <= ONE_LEVEL[LEVEL_W-1:0])
                 && (out_lvl_q[1] <= ONE_LEVEL[LEVEL_W-1:0])
                 && (out_lvl_q[2] <= ONE_LEVEL[LEVEL_W-1:0]))
    else $error("level above full white");

  // a red verdict needs red strictly ahead of both others
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_cls_q == CLS_RED
      |-> out_lvl_q[0] > out_lvl_q[1] && out_lvl_q[0] > out_lvl_q[2])
    else $error("red class without red dominance");

  // white needs every channel lit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_cls_q == CLS_WHITE
      |-> out_lvl_q[0] != '0 && out_lvl_q[1] != '0 && out_lvl_q[2] != '0)
    else $error("white class with a dark channel");

  // a held result must not be overwritten by the row behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_cls_q))
    else $error("stalled result lost");
`endif

endmodule

// ===== sv/cnc_div_cell.sv =====
module cnc_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  cnc_pkg::trip_t  data_i,
  input  cnc_pkg::freq3_t divisor_i,
  output logic            valid_o,
  input  logic            ready_i,
  output cnc_pkg::trip_t  data_o
);
  import cnc_pkg::*;

  logic                          valid_q;
  trip_t                         data_q, data_d;
  logic [NUM_CH-1:0][FREQ_W:0]   shifted;
  logic [NUM_CH-1:0][FREQ_W:0]   reduced;
  logic [NUM_CH-1:0]             ge;

  // one restoring step per channel: one quotient bit
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      shifted[c]     = {data_i[c].rem, 1'b0};
      reduced[c]     = shifted[c] - {1'b0, divisor_i[c]};
      ge[c]          = shifted[c] >= {1'b0, divisor_i[c]};
      data_d[c].kind = data_i[c].kind;
      data_d[c].rem  = ge[c] ? reduced[c][FREQ_W-1:0] : shifted[c][FREQ_W-1:0];
      data_d[c].quo  = {data_i[c].quo[FRAC_BITS-2:0], ge[c]};
    end
  end

  assign ready_o = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== sv/cnc_classify.sv =====
module cnc_classify (
  input  cnc_pkg::trip_t   data_i,
  output cnc_pkg::level3_t levels_o,
  output cnc_pkg::cls_e    class_o
);
  import cnc_pkg::*;

  level_t           r, g, b;
  logic [TH_W-1:0]  r5, g5, b5, r10, g10, b10, r20, g20, b20;

  // final level from the division kind
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      case (data_i[c].kind)
        KIND_ZERO: levels_o[c] = '0;
        KIND_SAT:  levels_o[c] = ONE_LEVEL[LEVEL_W-1:0];
        default:   levels_o[c] = {1'b0, data_i[c].quo};
      endcase
    end
  end

  assign r = levels_o[0];
  assign g = levels_o[1];
  assign b = levels_o[2];

  assign r5  = TH_W'(r) * TH_W'(5);
  assign g5  = TH_W'(g) * TH_W'(5);
  assign b5  = TH_W'(b) * TH_W'(5);
  assign r10 = TH_W'(r) * TH_W'(10);
  assign g10 = TH_W'(g) * TH_W'(10);
  assign b10 = TH_W'(b) * TH_W'(10);
  assign r20 = TH_W'(r) * TH_W'(20);
  assign g20 = TH_W'(g) * TH_W'(20);
  assign b20 = TH_W'(b) * TH_W'(20);

  // first match wins
  always_comb begin
    if (r > g && r > b && r5 > ONE_LEVEL) begin
      class_o = CLS_RED;
    end else if (g > r && g > b && g20 > ONE_LEVEL) begin
      class_o = CLS_GREEN;
    end else if (b > r && b > g && b5 > ONE_LEVEL) begin
      class_o = CLS_BLUE;
    end else if (r20 > TH_W'(7) * ONE_LEVEL && g20 > TH_W'(7) * ONE_LEVEL
                 && b20 > TH_W'(7) * ONE_LEVEL) begin
      class_o = CLS_WHITE;
    end else if (r10 < ONE_LEVEL && g10 < ONE_LEVEL && b10 < ONE_LEVEL) begin
      class_o = CLS_BLACK;
    end else begin
      class_o = CLS_UNKNOWN;
    end
  end

endmodule

// ===== tb/sv/color_normalize_classify_tb.sv =====
`timescale 1ns / 100ps

module color_normalize_classify_tb;
  import cnc_pkg::*;

  // channel order inside a triple and the packing of the result beat
  localparam int CH_RED    = 0;
  localparam int CH_GREEN  = 1;
  localparam int CH_BLUE   = 2;
  localparam int RED_LSB   = 0;
  localparam int GREEN_LSB = LEVEL_W;
  localparam int BLUE_LSB  = 2 * LEVEL_W;
  localparam int CLASS_LSB = 3 * LEVEL_W;

  localparam freq_t FREQ_MAX = {FREQ_W{1'b1}};

  // register indexes beyond the six calibration points, writes there do nothing
  localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  // class thresholds as fractions of full white
  localparam int unsigned RB_NUM    = 1;
  localparam int unsigned RB_DEN    = 5;
  localparam int unsigned GREEN_NUM = 1;
  localparam int unsigned GREEN_DEN = 20;
  localparam int unsigned WHITE_NUM = 7;
  localparam int unsigned WHITE_DEN = 20;
  localparam int unsigned BLACK_NUM = 1;
  localparam int unsigned BLACK_DEN = 10;

  // time to let any straggler after the last result come out before the end
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
    cls_e   colour;
  } colour_result_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [IDX_W-1:0]       cfg_index_i     = '0;
  logic [FREQ_W-1:0]      cfg_data_i      = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  // calibration points as the block should currently hold them
  freq_t black_pt [NUM_CH];
  freq_t white_pt [NUM_CH];

  // one entry per accepted triple, oldest first
  colour_result_t expected_colours [$];
  colour_result_t want;

  int unsigned send_idle_pct  = 14;
  int unsigned recv_stall_pct = 86;
  int          error_count    = 0;

  always #1 clk_i = ~clk_i;

  color_normalize_classify i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // (v - black) / (white - black) in Q1.16, truncated, clamped to one; a dead
  // channel (white not above black) or a reading at or below black gives zero
  function automatic level_t channel_level(freq_t v, freq_t blk, freq_t wht);
    logic [63:0] quo;
    if (wht <= blk || v <= blk) return '0;
    quo = (64'(v - blk) << FRAC_BITS) / 64'(wht - blk);
    if (quo > (64'd1 << FRAC_BITS)) quo = 64'd1 << FRAC_BITS;
    return level_t'(quo);
  endfunction

  // exact comparisons of a level against num/den of full white
  function automatic bit level_exceeds(level_t q, int unsigned num, int unsigned den);
    return 64'(q) * 64'(den) > (64'(num) << FRAC_BITS);
  endfunction

  function automatic bit level_under(level_t q, int unsigned num, int unsigned den);
    return 64'(q) * 64'(den) < (64'(num) << FRAC_BITS);
  endfunction

  // first match wins: dominant colour, then white, then black
  function automatic cls_e classify_colour(level_t r, level_t g, level_t b);
    if (r > g && r > b && level_exceeds(r, RB_NUM, RB_DEN)) return CLS_RED;
    if (g > r && g > b && level_exceeds(g, GREEN_NUM, GREEN_DEN)) return CLS_GREEN;
    if (b > r && b > g && level_exceeds(b, RB_NUM, RB_DEN)) return CLS_BLUE;
    if (level_exceeds(r, WHITE_NUM, WHITE_DEN) && level_exceeds(g, WHITE_NUM, WHITE_DEN) &&
        level_exceeds(b, WHITE_NUM, WHITE_DEN)) return CLS_WHITE;
    if (level_under(r, BLACK_NUM, BLACK_DEN) && level_under(g, BLACK_NUM, BLACK_DEN) &&
        level_under(b, BLACK_NUM, BLACK_DEN)) return CLS_BLACK;
    return CLS_UNKNOWN;
  endfunction

  function automatic colour_result_t predict_colour(freq_t red, freq_t green, freq_t blue);
    colour_result_t res;
    res.red    = channel_level(red, black_pt[CH_RED], white_pt[CH_RED]);
    res.green  = channel_level(green, black_pt[CH_GREEN], white_pt[CH_GREEN]);
    res.blue   = channel_level(blue, black_pt[CH_BLUE], white_pt[CH_BLUE]);
    res.colour = classify_colour(res.red, res.green, res.blue);
    return res;
  endfunction

  // frequency that lands near a wanted level on the present calibration;
  // a dead channel gets anything, since it reads zero regardless
  function automatic freq_t freq_for_level(int ch, int unsigned lvl);
    logic [63:0] f;
    if (white_pt[ch] <= black_pt[ch]) return freq_t'($urandom);
    f = 64'(black_pt[ch]) + ((64'(lvl) * 64'(white_pt[ch] - black_pt[ch])) >> FRAC_BITS);
    if (f > 64'(FREQ_MAX)) f = 64'(FREQ_MAX);
    return freq_t'(f);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers, every task starts and ends on a rising edge
  // ---------------------------------------------------------------------------

  // one triple onto the slave stream, with random idle cycles in front;
  // tvalid is left high so a back-to-back beat needs no second assignment
  task automatic send_triple(freq_t red, freq_t green, freq_t blue);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_TDATA_W'({blue, green, red});
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_colours.push_back(predict_colour(red, green, blue));
  endtask

  // one calibration write, cfg_valid_i stays high for a following write
  task automatic write_cal(logic [IDX_W-1:0] idx, freq_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_BLACK_RED:   black_pt[CH_RED]   = value;
      REG_BLACK_GREEN: black_pt[CH_GREEN] = value;
      REG_BLACK_BLUE:  black_pt[CH_BLUE]  = value;
      REG_WHITE_RED:   white_pt[CH_RED]   = value;
      REG_WHITE_GREEN: white_pt[CH_GREEN] = value;
      REG_WHITE_BLUE:  white_pt[CH_BLUE]  = value;
      default: ;  // spare index, nothing changes
    endcase
  endtask

  // all six points, optionally followed by writes to the spare indexes
  task automatic load_calibration(freq_t br, freq_t bg, freq_t bb,
                                  freq_t wr, freq_t wg, freq_t wb, bit with_spare);
    write_cal(REG_BLACK_RED, br);
    write_cal(REG_BLACK_GREEN, bg);
    write_cal(REG_BLACK_BLUE, bb);
    write_cal(REG_WHITE_RED, wr);
    write_cal(REG_WHITE_GREEN, wg);
    write_cal(REG_WHITE_BLUE, wb);
    if (with_spare) begin
      write_cal(IDX_SPARE_LO, freq_t'($urandom));
      write_cal(IDX_SPARE_HI, freq_t'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset points: black 0, white 1, so any non-zero reading is full white
  task automatic test_reset_points();
    send_triple(0, 0, 0);
    send_triple(1, 0, 0);
    send_triple(0, 1, 0);
    send_triple(0, 0, 1);
    send_triple(FREQ_MAX, FREQ_MAX, FREQ_MAX);
    send_triple(1, 1, 0);  // red and green tie, nothing dominates
  endtask

  // white at 65536 over black 0 makes each level equal its reading,
  // so every threshold can be hit one step either side
  task automatic test_thresholds();
    drain_results();
    load_calibration(0, 0, 0, 65536, 65536, 65536, 1'b0);
    send_triple(13108, 0, 0);
    send_triple(13107, 0, 0);
    send_triple(0, 3277, 0);
    send_triple(0, 3276, 0);
    send_triple(0, 0, 13108);
    send_triple(22938, 22938, 22938);
    send_triple(22937, 22937, 22937);
    send_triple(6553, 6553, 6553);
    send_triple(6554, 6554, 6554);
    send_triple(65536, 65537, 65535);  // at and above white, clamped tie
  endtask

  // white equal to black, white below black, full-scale span, spare indexes,
  // then readings below and at black
  task automatic test_degenerate_points();
    drain_results();
    load_calibration(500000, FREQ_MAX, 0, 500000, 0, FREQ_MAX, 1'b1);
    send_triple(FREQ_MAX, FREQ_MAX, FREQ_MAX);
    send_triple(0, 0, 0);
    send_triple(500000, 0, 524288);
    send_triple(499999, 123, 1);
    drain_results();
    load_calibration(1000, 2000, 3000, 201000, 82000, 603000, 1'b1);
    send_triple(999, 1999, 2999);
    send_triple(1000, 2000, 3000);
    send_triple(201000, 2000, 3000);
  endtask

  // random but sensible points per channel, now and then a dead channel
  // or the full 20-bit span
  task automatic load_random_points();
    freq_t blk [NUM_CH];
    freq_t wht [NUM_CH];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      case ($urandom_range(9))
        0: begin
          blk[ch] = freq_t'($urandom);
          wht[ch] = freq_t'($urandom_range(blk[ch]));
        end
        1: begin
          blk[ch] = '0;
          wht[ch] = FREQ_MAX;
        end
        default: begin
          blk[ch] = freq_t'($urandom_range(200000));
          wht[ch] = blk[ch] + freq_t'($urandom_range(800000, 1));
        end
      endcase
    end
    load_calibration(blk[CH_RED], blk[CH_GREEN], blk[CH_BLUE],
                     wht[CH_RED], wht[CH_GREEN], wht[CH_BLUE], $urandom_range(3) == 0);
  endtask

  // mostly triples aimed at one class on the present calibration, the rest
  // raw 20-bit noise
  task automatic send_random_triple();
    int unsigned lvl [NUM_CH];
    int unsigned top;
    int          aim;
    if ($urandom_range(99) < 25) begin
      send_triple(freq_t'($urandom), freq_t'($urandom), freq_t'($urandom));
    end else begin
      aim = $urandom_range(5);
      if (aim < NUM_CH) begin
        // one dominant channel, the others at or below it
        top = $urandom_range(80000, (aim == CH_GREEN) ? 2500 : 12000);
        for (int ch = 0; ch < NUM_CH; ch++) lvl[ch] = $urandom_range(top);
        lvl[aim] = top;
      end else if (aim == NUM_CH) begin
        for (int ch = 0; ch < NUM_CH; ch++) lvl[ch] = $urandom_range(80000, 20000);
      end else if (aim == NUM_CH + 1) begin
        for (int ch = 0; ch < NUM_CH; ch++) lvl[ch] = $urandom_range(8000);
      end else begin
        for (int ch = 0; ch < NUM_CH; ch++) lvl[ch] = $urandom_range(80000);
      end
      send_triple(freq_for_level(CH_RED, lvl[CH_RED]), freq_for_level(CH_GREEN, lvl[CH_GREEN]),
                  freq_for_level(CH_BLUE, lvl[CH_BLUE]));
    end
  endtask

  // one idling pattern, several calibrations, each loaded after a full drain
  task automatic test_random_phase(int unsigned send_pct, int unsigned recv_pct,
                                   int unsigned count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int blk = 0; blk < 5; blk++) begin
      drain_results();
      load_random_points();
      repeat (count / 5) send_random_triple();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver and checker
  // ---------------------------------------------------------------------------

  // random back-pressure on the master side
  always @(posedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);

  // every result beat against the oldest outstanding prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_colours.size() == 0) begin
        $error("result beat with no triple outstanding: tdata %h", m_axis_tdata_o);
        error_count++;
      end else begin
        want = expected_colours.pop_front();
        if (m_axis_tdata_o[RED_LSB +: LEVEL_W] !== want.red) begin
          $error("norm_red: expected %0d, got %0d", want.red, m_axis_tdata_o[RED_LSB +: LEVEL_W]);
          error_count++;
        end
        if (m_axis_tdata_o[GREEN_LSB +: LEVEL_W] !== want.green) begin
          $error("norm_green: expected %0d, got %0d", want.green,
                 m_axis_tdata_o[GREEN_LSB +: LEVEL_W]);
          error_count++;
        end
        if (m_axis_tdata_o[BLUE_LSB +: LEVEL_W] !== want.blue) begin
          $error("norm_blue: expected %0d, got %0d", want.blue,
                 m_axis_tdata_o[BLUE_LSB +: LEVEL_W]);
          error_count++;
        end
        if (m_axis_tdata_o[CLASS_LSB +: CLASS_W] !== want.colour) begin
          $error("color_class: expected %0d, got %0d", want.colour,
                 m_axis_tdata_o[CLASS_LSB +: CLASS_W]);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    black_pt = '{default: '0};
    white_pt = '{default: freq_t'(1)};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_points();
    test_thresholds();
    test_degenerate_points();
    test_random_phase(14, 86, 350);
    test_random_phase(86, 14, 350);
    test_random_phase(0, 0, 350);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
